### hdl/variable_message_ring_queue_assert.svh
// assertion macros for the message ring queue
`ifndef VARIABLE_MESSAGE_RING_QUEUE_ASSERT_SVH
`define VARIABLE_MESSAGE_RING_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define VMRQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define VMRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VMRQ_ASSERT_ALWAYS(lbl, cond, msg)
`define VMRQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/vmrq_pkg.sv
// shared constants and controller/datapath types for the message ring queue
package vmrq_pkg;
    localparam int RING_DEPTH_DEF   = 1024;
    localparam int HEADER_WORDS_DEF = 2;
    localparam int RING_WORDS_RESET = 1024;
    localparam int MARGIN_RESET     = 8;
    localparam int RING_WORDS_MIN   = 16;

    localparam logic [31:0] SKIP_TYPE = 32'hFFFF_FFFF;

    localparam int WORD_W   = 64;
    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 208;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_RESERVE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUT     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CONSUME = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_WORDS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MARGIN = 1'd1;

    typedef struct packed {
        logic load;
        logic res_chk;
        logic hdr_wr;
        logic put;
        logic commit;
        logic bad;
        logic hd_chk;
        logic hd_w0;
        logic hd_t;
        logic hd_off;
        logic hd_d;
        logic emit;
    } t_vmrq_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic fin;
        logic retry;
        logic hdr_last;
        logic out_free;
    } t_vmrq_stat;
endpackage

### hdl/vmrq_ctrl.sv
// request sequencer for the message ring queue
module vmrq_ctrl #(
    parameter int HEADER_WORDS = vmrq_pkg::HEADER_WORDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  vmrq_pkg::t_vmrq_stat i_stat,
    output vmrq_pkg::t_vmrq_cmd  o_cmd
);
    import vmrq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RES_CHK, S_HDR, S_PUT, S_COMMIT, S_BAD,
        S_HD_CHK, S_HD_W0, S_HD_T, S_HD_OFF, S_HD_D, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_cmd = '0;
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.res_chk = (r_state == S_RES_CHK);
        o_cmd.hdr_wr  = (r_state == S_HDR);
        o_cmd.put     = (r_state == S_PUT);
        o_cmd.commit  = (r_state == S_COMMIT);
        o_cmd.bad     = (r_state == S_BAD);
        o_cmd.hd_chk  = (r_state == S_HD_CHK);
        o_cmd.hd_w0   = (r_state == S_HD_W0);
        o_cmd.hd_t    = (r_state == S_HD_T);
        o_cmd.hd_off  = (r_state == S_HD_OFF);
        o_cmd.hd_d    = (r_state == S_HD_D);
        o_cmd.emit    = (r_state == S_DONE) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_stat.kind)
                    KIND_RESERVE: n_state = S_RES_CHK;
                    KIND_PUT:     n_state = S_PUT;
                    KIND_COMMIT:  n_state = S_COMMIT;
                    KIND_PEEK, KIND_READ, KIND_CONSUME: n_state = S_HD_CHK;
                    default:      n_state = S_BAD;
                endcase
            end
            S_RES_CHK: n_state = i_stat.fin ? S_DONE : S_HDR;
            S_HDR:     n_state = i_stat.hdr_last ? S_DONE : S_HDR;
            S_PUT, S_COMMIT, S_BAD: n_state = S_DONE;
            S_HD_CHK:  n_state = i_stat.fin ? S_DONE : S_HD_W0;
            S_HD_W0: begin
                if (i_stat.fin) n_state = S_DONE;
                else if (i_stat.retry) n_state = S_HD_W0;
                else if (HEADER_WORDS >= 2) n_state = S_HD_T;
                else n_state = S_HD_OFF;
            end
            S_HD_T:    n_state = S_HD_OFF;
            S_HD_OFF:  n_state = i_stat.fin ? S_DONE : S_HD_D;
            S_HD_D:    n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### hdl/vmrq_dp.sv
// ring memory, pointers, fill counters and result register
`include "variable_message_ring_queue_assert.svh"
module vmrq_dp #(
    parameter int RING_DEPTH   = vmrq_pkg::RING_DEPTH_DEF,
    parameter int HEADER_WORDS = vmrq_pkg::HEADER_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vmrq_pkg::t_vmrq_cmd               i_cmd,
    output vmrq_pkg::t_vmrq_stat              o_stat,
    input  logic [vmrq_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic [vmrq_pkg::KIND_W-1:0]       i_in_kind,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [vmrq_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic [vmrq_pkg::STATUS_W-1:0]     o_out_status,
    input  logic                              i_cfg_we,
    input  logic [vmrq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vmrq_pkg::CFG_W-1:0]        i_cfg_data
);
    import vmrq_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = AW + 1;
    localparam int HW = (HEADER_WORDS > 1) ? $clog2(HEADER_WORDS) : 1;
    localparam int RW_RESET = (RING_WORDS_RESET > RING_DEPTH) ? RING_DEPTH : RING_WORDS_RESET;

    logic [WORD_W-1:0] r_mem [RING_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // latched request
    logic [KIND_W-1:0] r_kind;
    logic [9:0]        r_size;
    logic [31:0]       r_type;
    logic [63:0]       r_now;
    logic [63:0]       r_din;
    logic [9:0]        r_off;

    logic [AW-1:0]     r_wp, r_rp, r_rstart;
    logic [9:0]        r_cnt, r_rlen, r_pcur;
    logic              r_open, r_skipped;
    logic [HW-1:0]     r_hcnt;
    logic [CW-1:0]     r_rw;
    logic [CFG_W-1:0]  r_margin;

    logic [STATUS_W-1:0] r_status;
    logic [9:0]        r_hsize;
    logic [31:0]       r_htype;
    logic [63:0]       r_htime, r_dout;

    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [STATUS_W-1:0] r_out_status;

    logic [CW-1:0] free_w, used_w;
    logic [31:0]   total, commit_end, next_rp;
    logic          res_bad, nospace, fits, first_skip, put_ok, off_bad, wp_ge_rp;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [WORD_W-1:0] mem_wd, hdr_word;
    logic [31:0]   cfg_rw;

    always_comb begin
        wp_ge_rp = r_wp >= r_rp;
        free_w = wp_ge_rp ? CW'(r_rw - CW'(r_wp) + CW'(r_rp)) : CW'(r_rp - r_wp);
        used_w = wp_ge_rp ? CW'(r_wp - r_rp) : CW'(r_rw - CW'(r_rp) + CW'(r_wp));
        total      = 32'(HEADER_WORDS) + 32'(r_size);
        res_bad    = r_open || (r_type == SKIP_TYPE);
        nospace    = 32'(free_w) <= total;
        fits       = 32'(r_wp) + total <= 32'(r_rw);
        first_skip = (r_rdata[63:32] == SKIP_TYPE) && !r_skipped;
        put_ok     = r_open && (r_pcur < r_rlen);
        off_bad    = r_off >= r_hsize;
        commit_end = 32'(r_rstart) + 32'(HEADER_WORDS) + 32'(r_rlen);
        next_rp    = 32'(r_rp) + 32'(HEADER_WORDS) + r_rdata[31:0];
        cfg_rw = 32'(i_cfg_data);
        if (cfg_rw < 32'(RING_WORDS_MIN)) cfg_rw = 32'(RING_WORDS_MIN);
        else if (cfg_rw > 32'(RING_DEPTH)) cfg_rw = 32'(RING_DEPTH);

        if (r_hcnt == '0) hdr_word = {r_type, 22'd0, r_size};
        else if (HEADER_WORDS >= 2 && r_hcnt == HW'(1)) hdr_word = r_now;
        else hdr_word = '0;

        mem_we = 1'b0;
        mem_wa = r_wp;
        mem_wd = {SKIP_TYPE, 32'(r_rw - CW'(r_wp))};
        if (i_cmd.res_chk) begin
            // skip marker to the end of the ring
            mem_we = !res_bad && !nospace && !fits && (r_rp != '0);
        end else if (i_cmd.hdr_wr) begin
            mem_we = 1'b1;
            mem_wa = AW'(32'(r_rstart) + 32'(r_hcnt));
            mem_wd = hdr_word;
        end else if (i_cmd.put) begin
            mem_we = put_ok;
            mem_wa = AW'(32'(r_rstart) + 32'(HEADER_WORDS) + 32'(r_pcur));
            mem_wd = r_din;
        end

        if (i_cmd.hd_w0) mem_ra = first_skip ? '0 : AW'(32'(r_rp) + 32'd1);
        else if (i_cmd.hd_off) mem_ra = AW'(32'(r_rp) + 32'(HEADER_WORDS) + 32'(r_off));
        else mem_ra = r_rp;

        o_stat.kind     = r_kind;
        o_stat.retry    = i_cmd.hd_w0 && first_skip && (r_wp != '0);
        o_stat.hdr_last = (32'(r_hcnt) == 32'(HEADER_WORDS - 1));
        o_stat.out_free = !r_out_valid || i_out_ready;
        if (i_cmd.res_chk)
            o_stat.fin = res_bad || nospace ||
                         (!fits && ((r_rp == '0) || (32'(r_rp) <= total)));
        else if (i_cmd.hd_chk)
            o_stat.fin = (r_rp == r_wp);
        else if (i_cmd.hd_w0)
            o_stat.fin = first_skip ? (r_wp == '0) : (r_kind == KIND_CONSUME);
        else if (i_cmd.hd_off)
            o_stat.fin = (r_kind == KIND_PEEK) || off_bad;
        else
            o_stat.fin = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_in_kind;
            r_size <= i_in_data[9:0];
            r_type <= i_in_data[41:10];
            r_now  <= i_in_data[105:42];
            r_din  <= i_in_data[169:106];
            r_off  <= i_in_data[179:170];
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_data   <= {4'd0, (32'(free_w) < 32'(HEADER_WORDS) + 32'(r_margin)),
                             r_rp == r_wp, r_cnt, 11'(free_w), 11'(used_w),
                             r_dout, r_htime, r_htype, r_hsize};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_rstart <= '0;
            r_cnt <= '0; r_rlen <= '0; r_pcur <= '0;
            r_open <= 1'b0; r_skipped <= 1'b0; r_hcnt <= '0;
            r_rw <= CW'(RW_RESET);
            r_margin <= CFG_W'(MARGIN_RESET);
            r_status <= ST_OK;
            r_hsize <= '0; r_htype <= '0; r_htime <= '0; r_dout <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;

            if (i_cfg_we) begin
                if (i_cfg_index == CFG_RING_WORDS) begin
                    r_rw <= CW'(cfg_rw);
                    r_wp <= '0; r_rp <= '0; r_cnt <= '0;
                    r_open <= 1'b0; r_rstart <= '0; r_rlen <= '0; r_pcur <= '0;
                end else begin
                    r_margin <= i_cfg_data;
                end
            end

            if (i_cmd.load) begin
                r_status <= ST_OK;
                r_skipped <= 1'b0;
                r_hsize <= '0; r_htype <= '0; r_htime <= '0; r_dout <= '0;
            end

            if (i_cmd.res_chk) begin
                r_hcnt <= '0;
                if (res_bad) r_status <= ST_BAD;
                else if (nospace) r_status <= ST_NOSPACE;
                else if (!fits) begin
                    if (r_rp == '0) r_status <= ST_NOSPACE;
                    else begin
                        r_wp <= '0;
                        r_rstart <= '0;
                        if (32'(r_rp) <= total) r_status <= ST_NOSPACE;
                    end
                end else begin
                    r_rstart <= r_wp;
                end
            end

            if (i_cmd.hdr_wr) begin
                r_hcnt <= HW'(r_hcnt + 1'b1);
                if (32'(r_hcnt) == 32'(HEADER_WORDS - 1)) begin
                    r_open <= 1'b1;
                    r_rlen <= r_size;
                    r_pcur <= '0;
                end
            end

            if (i_cmd.put) begin
                if (put_ok) r_pcur <= r_pcur + 10'd1;
                else r_status <= ST_BAD;
            end

            if (i_cmd.commit) begin
                if (!r_open) r_status <= ST_BAD;
                else begin
                    r_wp <= (commit_end >= 32'(r_rw)) ? '0 : AW'(commit_end);
                    if (r_cnt != 10'd1023) r_cnt <= r_cnt + 10'd1;
                    r_open <= 1'b0;
                end
            end

            if (i_cmd.bad) r_status <= ST_BAD;

            if (i_cmd.hd_chk && (r_rp == r_wp)) r_status <= ST_EMPTY;

            if (i_cmd.hd_w0) begin
                if (first_skip) begin
                    // pass the skip marker and look again at word 0
                    r_rp <= '0;
                    r_skipped <= 1'b1;
                    if (r_wp == '0) r_status <= ST_EMPTY;
                end else if (r_kind == KIND_CONSUME) begin
                    r_rp <= (next_rp >= 32'(r_rw)) ? '0 : AW'(next_rp);
                    if (r_cnt != '0) r_cnt <= r_cnt - 10'd1;
                end else begin
                    r_hsize <= r_rdata[9:0];
                    r_htype <= r_rdata[63:32];
                end
            end

            if (i_cmd.hd_t) r_htime <= r_rdata;

            if (i_cmd.hd_off && (r_kind == KIND_READ) && off_bad) r_status <= ST_BAD;

            if (i_cmd.hd_d) r_dout <= r_rdata;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;

    `VMRQ_ASSERT_ALWAYS(a_wp_in_ring, {1'b0, r_wp} < r_rw, "write position past ring end")
    `VMRQ_ASSERT_ALWAYS(a_rp_in_ring, {1'b0, r_rp} < r_rw, "read position past ring end")
    `VMRQ_ASSERT_ALWAYS(a_put_bound, !r_open || (r_pcur <= r_rlen), "put cursor past reservation")
    `VMRQ_ASSERT_NEXT(a_emit_shows, i_cmd.emit, r_out_valid, "result not presented after emit")
endmodule

### hdl/variable_message_ring_queue.sv
// top level of the variable-length message ring queue
//
//  port group  | dir | tdata fields (low bit up)                        | tuser
//  s_axis      | in  | size_words, msg_type, now_time, data_in, word_offset | kind
//  m_axis      | out | head_size, head_type, head_time, data_out, used_words,
//              |     | free_words, message_count, empty_flag, full_flag | status
//  i_cfg_*     | in  | index 0 ring_words, index 1 full_margin          | -
//
// a request runs from decode through the states of its kind to a result state before
// the next word is taken; a reserve writes its HEADER_WORDS header words one by one
// (none when refused), consume reads the head's first word, peek and read fetch the
// header and read also a data word, with one more fetch past a skip marker; every ring
// access uses the registered read port of the single ring memory, so header reads chain.
// one request is in work at a time; the result register lets the next request be
// taken while a result waits on m_axis_tready. synchronous active-low reset clears
// pointers and counters at once; ring contents are not cleared.
module variable_message_ring_queue #(
    parameter int RING_DEPTH   = vmrq_pkg::RING_DEPTH_DEF,
    parameter int HEADER_WORDS = vmrq_pkg::HEADER_WORDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // size_words[9:0] msg_type[41:10] now_time[105:42] data_in[169:106] word_offset[179:170]
    input  logic [vmrq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind[2:0]
    input  logic [vmrq_pkg::KIND_W-1:0]        s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // head_size[9:0] head_type[41:10] head_time[105:42] data_out[169:106]
    // used_words[180:170] free_words[191:181] message_count[201:192]
    // empty_flag[202] full_flag[203]
    output logic [vmrq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status[1:0]
    output logic [vmrq_pkg::STATUS_W-1:0]      m_axis_tuser,
    input  logic                               i_cfg_we,
    input  logic [vmrq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [vmrq_pkg::CFG_W-1:0]         i_cfg_data
);
    import vmrq_pkg::*;

    t_vmrq_cmd  cmd;
    t_vmrq_stat stat;

    vmrq_ctrl #(
        .HEADER_WORDS (HEADER_WORDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vmrq_dp #(
        .RING_DEPTH   (RING_DEPTH),
        .HEADER_WORDS (HEADER_WORDS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_in_data    (s_axis_tdata),
        .i_in_kind    (s_axis_tuser),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );
endmodule

### test/variable_message_ring_queue_tb.sv
// testbench for the variable-length message ring queue: predictor, driver, monitor
`timescale 1ns / 1ps

module variable_message_ring_queue_tb;
    import vmrq_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;
    localparam int HDR = HEADER_WORDS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [9:0] size_words;
        logic [31:0] msg_type;
        logic [63:0] now_time;
        logic [63:0] data_in;
        logic [9:0] word_offset;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [9:0] head_size;
        logic [31:0] head_type;
        logic [63:0] head_time;
        logic [63:0] data_out;
        logic [10:0] used_words;
        logic [10:0] free_words;
        logic [9:0] message_count;
        logic empty_flag;
        logic full_flag;
    } resp_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [KIND_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    variable_message_ring_queue dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0] ring_mem [DEPTH];
    bit ring_written [DEPTH];
    int unsigned wr_pos, rd_pos, msg_cnt, res_start, res_len, put_cur;
    bit res_open;
    int unsigned ring_size = RING_WORDS_RESET, margin = MARGIN_RESET;

    req_t pending_reqs[$];
    resp_t expected_resps[$];
    int errors = 0, accepted = 0, received = 0;
    int idle_pct = 0, stall_pct = 0;
    bit hold_rx = 1'b0;
    int n_ok = 0, n_nospace = 0, n_empty = 0, n_bad = 0;

    function automatic int unsigned free_now();
        return (wr_pos >= rd_pos) ? ring_size - wr_pos + rd_pos : rd_pos - wr_pos;
    endfunction

    function automatic int unsigned used_now();
        return (wr_pos >= rd_pos) ? wr_pos - rd_pos : ring_size - rd_pos + wr_pos;
    endfunction

    function automatic void ring_put(int unsigned a, logic [63:0] v);
        if (a < DEPTH) begin
            ring_mem[a] = v;
            ring_written[a] = 1'b1;
        end
    endfunction

    function automatic logic [63:0] ring_get(int unsigned a);
        return (a < DEPTH && ring_written[a]) ? ring_mem[a] : 64'd0;
    endfunction

    function automatic void empty_ring();
        wr_pos = 0; rd_pos = 0; msg_cnt = 0; res_open = 0;
        res_start = 0; res_len = 0; put_cur = 0;
    endfunction

    function automatic bit head_ready();
        logic [63:0] w;
        if (rd_pos == wr_pos) return 1'b0;
        w = ring_get(rd_pos);
        if (w[63:32] == SKIP_TYPE) begin
            rd_pos = 0;
            if (rd_pos == wr_pos) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic resp_t predict_queue_step(req_t r);
        resp_t o;
        int unsigned total, fr, sz;
        logic [63:0] w0;
        o = '0;
        o.status = ST_OK;
        case (r.kind)
            KIND_RESERVE: begin
                total = HDR + r.size_words;
                if (res_open || r.msg_type == SKIP_TYPE) o.status = ST_BAD;
                else if (free_now() <= total) o.status = ST_NOSPACE;
                else begin
                    if (wr_pos + total > ring_size) begin
                        if (rd_pos == 0) o.status = ST_NOSPACE;
                        else begin
                            ring_put(wr_pos, {SKIP_TYPE, 32'(ring_size - wr_pos)});
                            wr_pos = 0;
                            if (rd_pos <= total) o.status = ST_NOSPACE;
                        end
                    end
                    if (o.status == ST_OK) begin
                        ring_put(wr_pos, {r.msg_type, 22'd0, r.size_words});
                        for (int i = 1; i < HDR; i++)
                            ring_put(wr_pos + i, (i == 1) ? r.now_time : 64'd0);
                        res_open = 1; res_start = wr_pos;
                        res_len = r.size_words; put_cur = 0;
                    end
                end
            end
            KIND_PUT: begin
                if (!res_open || put_cur >= res_len) o.status = ST_BAD;
                else begin
                    ring_put(res_start + HDR + put_cur, r.data_in);
                    put_cur++;
                end
            end
            KIND_COMMIT: begin
                if (!res_open) o.status = ST_BAD;
                else begin
                    total = res_start + HDR + res_len;
                    wr_pos = (total >= ring_size) ? 0 : total;
                    if (msg_cnt < 1023) msg_cnt++;
                    res_open = 0;
                end
            end
            KIND_PEEK, KIND_READ, KIND_CONSUME: begin
                if (!head_ready()) o.status = ST_EMPTY;
                else begin
                    w0 = ring_get(rd_pos);
                    sz = w0[31:0];
                    if (r.kind == KIND_CONSUME) begin
                        total = rd_pos + HDR + sz;
                        rd_pos = (total >= ring_size) ? 0 : total;
                        if (msg_cnt > 0) msg_cnt--;
                    end else begin
                        o.head_size = sz[9:0];
                        o.head_type = w0[63:32];
                        o.head_time = ring_get(rd_pos + 1);
                        if (r.kind == KIND_READ) begin
                            if (r.word_offset >= sz) o.status = ST_BAD;
                            else o.data_out = ring_get(rd_pos + HDR + r.word_offset);
                        end
                    end
                end
            end
            default: o.status = ST_BAD;
        endcase
        fr = free_now();
        o.used_words = 11'(used_now());
        o.free_words = 11'(fr);
        o.message_count = 10'(msg_cnt);
        o.empty_flag = (rd_pos == wr_pos);
        o.full_flag = (fr < HDR + margin);
        return o;
    endfunction

    // input word taken at the last rising edge
    logic in_fire = 1'b0;
    always @(posedge i_clk) begin
        in_fire <= s_axis_tvalid && s_axis_tready;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_fire) begin
                // hold the word
            end else if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_reqs[0].kind;
                s_axis_tdata <= {4'd0, pending_reqs[0].word_offset, pending_reqs[0].data_in,
                    pending_reqs[0].now_time, pending_reqs[0].msg_type,
                    pending_reqs[0].size_words};
                void'(pending_reqs.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= !hold_rx && ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // monitor and prediction on accept
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        resp_t got, want;
        req_t r;
        bit fired;
        if (i_rst_n) begin
            fired = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                r.kind = s_axis_tuser;
                {r.word_offset, r.data_in, r.now_time, r.msg_type, r.size_words} =
                    s_axis_tdata[179:0];
                expected_resps.push_back(predict_queue_step(r));
                accepted++;
                fired = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                fired = 1'b1;
                got = '0;
                got.status = m_axis_tuser;
                {got.full_flag, got.empty_flag, got.message_count, got.free_words,
                    got.used_words, got.data_out, got.head_time, got.head_type,
                    got.head_size} = m_axis_tdata[203:0];
                received++;
                if (expected_resps.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word %h", $time, got);
                end else begin
                    want = expected_resps.pop_front();
                    case (want.status)
                        ST_OK: n_ok++;
                        ST_EMPTY: n_empty++;
                        ST_NOSPACE: n_nospace++;
                        default: n_bad++;
                    endcase
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        if (got.status !== want.status)
                            $display("  status exp %0d act %0d", want.status, got.status);
                        if (got.data_out !== want.data_out)
                            $display("  data_out exp %h act %h", want.data_out, got.data_out);
                        if ({got.used_words, got.free_words, got.message_count} !==
                            {want.used_words, want.free_words, want.message_count})
                            $display("  fill exp %0d/%0d/%0d act %0d/%0d/%0d",
                                want.used_words, want.free_words, want.message_count,
                                got.used_words, got.free_words, got.message_count);
                    end
                end
            end
            quiet_cycles <= fired ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic req_t mk_req(logic [KIND_W-1:0] k, int sz = 0);
        req_t r;
        r.kind = k;
        r.size_words = 10'(sz);
        r.msg_type = $urandom();
        if (r.msg_type == SKIP_TYPE) r.msg_type = 0;
        r.now_time = {$urandom(), $urandom()};
        r.data_in = {$urandom(), $urandom()};
        r.word_offset = 10'($urandom_range(3, 0));
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_resps.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= CFG_W'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RING_WORDS) begin
            ring_size = (v < RING_WORDS_MIN) ? RING_WORDS_MIN : (v > DEPTH ? DEPTH : v);
            empty_ring();
        end else margin = v;
    endtask

    // a full message: reserve, random number of puts, commit
    task automatic queue_message(int max_sz, bit full_puts);
        int sz, n;
        sz = ($urandom_range(9, 0) == 0) ? $urandom_range(max_sz, 0)
                                          : $urandom_range(max_sz < 6 ? max_sz : 6, 0);
        pending_reqs.push_back(mk_req(KIND_RESERVE, sz));
        n = (!full_puts && $urandom_range(7, 0) == 0) ? $urandom_range(sz + 1, 0) : sz;
        for (int i = 0; i < n; i++) pending_reqs.push_back(mk_req(KIND_PUT));
        pending_reqs.push_back(mk_req(KIND_COMMIT));
    endtask

    // full_puts: every reservation gets all its words, for rings reaching unused memory
    task automatic random_burst(int count, int max_sz, bit full_puts = 1'b0);
        req_t r;
        int p;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(99, 0);
            if (p < 40) queue_message(max_sz, full_puts);
            else if (p < 85) begin
                pending_reqs.push_back(mk_req(KIND_PEEK));
                r = mk_req(KIND_READ);
                r.word_offset = ($urandom_range(9, 0) == 0) ? 10'($urandom())
                                                             : 10'($urandom_range(7, 0));
                pending_reqs.push_back(r);
                pending_reqs.push_back(mk_req(KIND_CONSUME));
            end else begin
                r = mk_req(3'($urandom_range(7, 0)), $urandom_range(max_sz, 0));
                r.word_offset = 10'($urandom());
                if ($urandom_range(3, 0) == 0) r.msg_type = SKIP_TYPE;
                if (full_puts && r.kind == KIND_RESERVE) r.msg_type = SKIP_TYPE;
                r.size_words = ($urandom_range(15, 0) == 0) ? 10'($urandom()) : r.size_words;
                pending_reqs.push_back(r);
            end
        end
    endtask

    initial begin
        req_t r;
        empty_ring();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the low 64 ring words before any partly filled message
        pending_reqs.push_back(mk_req(KIND_RESERVE, 62));
        for (int i = 0; i < 62; i++) pending_reqs.push_back(mk_req(KIND_PUT));
        pending_reqs.push_back(mk_req(KIND_COMMIT));
        pending_reqs.push_back(mk_req(KIND_CONSUME));

        // directed: empty ops, bad kinds, refused type, extremes
        pending_reqs.push_back(mk_req(KIND_PEEK));
        pending_reqs.push_back(mk_req(KIND_READ));
        pending_reqs.push_back(mk_req(KIND_CONSUME));
        pending_reqs.push_back(mk_req(KIND_PUT));
        pending_reqs.push_back(mk_req(KIND_COMMIT));
        pending_reqs.push_back(mk_req(3'd6));
        pending_reqs.push_back(mk_req(3'd7));
        r = mk_req(KIND_RESERVE, 1);
        r.msg_type = SKIP_TYPE;
        pending_reqs.push_back(r);
        r = mk_req(KIND_RESERVE, 1022);
        pending_reqs.push_back(r);
        r = mk_req(KIND_RESERVE, 2);
        r.msg_type = 32'hFFFF_FFFE; r.now_time = '1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(mk_req(KIND_RESERVE, 1));
        r = mk_req(KIND_PUT); r.data_in = '1;
        pending_reqs.push_back(r);
        r = mk_req(KIND_PUT); r.data_in = '0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(mk_req(KIND_PUT));
        pending_reqs.push_back(mk_req(KIND_COMMIT));
        pending_reqs.push_back(mk_req(KIND_PEEK));
        r = mk_req(KIND_READ); r.word_offset = 1;
        pending_reqs.push_back(r);
        r = mk_req(KIND_READ); r.word_offset = '1;
        pending_reqs.push_back(r);
        pending_reqs.push_back(mk_req(KIND_CONSUME));
        r = mk_req(KIND_RESERVE, 0); r.msg_type = 0; r.now_time = 0;
        pending_reqs.push_back(r);
        pending_reqs.push_back(mk_req(KIND_COMMIT));
        pending_reqs.push_back(mk_req(KIND_PEEK));
        pending_reqs.push_back(mk_req(KIND_CONSUME));
        pending_reqs.push_back(mk_req(KIND_CONSUME));

        // small ring: wrap, skip markers, full ring; no idling
        write_reg(CFG_RING_WORDS, 0);
        write_reg(CFG_FULL_MARGIN, 0);
        random_burst(80, 12);

        // receiver holds off while requests keep coming
        wait_drained();
        hold_rx = 1'b1;
        random_burst(20, 6);
        repeat (300) @(posedge i_clk);
        hold_rx = 1'b0;
        wait_drained();

        write_reg(CFG_RING_WORDS, 40);
        write_reg(CFG_FULL_MARGIN, 1024);
        idle_pct = 88;
        random_burst(60, 20);

        write_reg(CFG_RING_WORDS, 2047);
        write_reg(CFG_FULL_MARGIN, 2047);
        idle_pct = 0; stall_pct = 88;
        random_burst(60, 40, 1'b1);

        write_reg(CFG_RING_WORDS, 64);
        write_reg(CFG_FULL_MARGIN, 5);
        idle_pct = 13; stall_pct = 13;
        random_burst(70, 30);

        write_reg(CFG_RING_WORDS, 1024);
        write_reg(CFG_FULL_MARGIN, 8);
        idle_pct = 0; stall_pct = 0;
        random_burst(12, 1022, 1'b1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d requests: %0d ok, %0d empty, %0d no space, %0d bad",
            accepted, n_ok, n_empty, n_nospace, n_bad);
        $display("ring sizes 16, 40, 64, 1024 with margins 0 to 2047 and random stalls");
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hdl
hdl/vmrq_pkg.sv
hdl/vmrq_ctrl.sv
hdl/vmrq_dp.sv
hdl/variable_message_ring_queue.sv
test/variable_message_ring_queue_tb.sv
